/* hdl/fpte_pkg.sv */
// fern posterior table engine: shared constants, types and state codes
// no dependencies
package fpte_pkg;

    localparam int NumFerns   = 10;
    localparam int CodeBits   = 13;
    localparam int FernBits   = (NumFerns > 1) ? $clog2(NumFerns) : 1;
    localparam int AddrBits   = FernBits + CodeBits;
    localparam int Depth      = NumFerns * (1 << CodeBits);
    localparam int SumBits    = 19;
    localparam int CountBits  = 16;
    localparam int PostBits   = 16;
    localparam int CfgIdxBits = 1;

    localparam logic [SumBits-1:0]   PosThrReset = 19'd195363;
    localparam logic [SumBits-1:0]   NegThrReset = 19'd163840;
    localparam logic [CountBits-1:0] CountMax    = 16'hFFFF;

    localparam logic [CfgIdxBits-1:0] RegPosThr = 1'b0;
    localparam logic [CfgIdxBits-1:0] RegNegThr = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DECIDE,
        ST_UREAD,
        ST_UCOUNT,
        ST_UDIV,
        ST_UWRITE,
        ST_OUT
    } t_state;

endpackage

/* hdl/fern_posterior_table_engine.sv */
// fern posterior table engine, top level
// depends on fpte_pkg; holds the count and posterior memories
//
// Each input transfer carries one leaf code per fern. The block reads the
// posterior of every addressed leaf from a registered-read memory, one
// fern at a time (a read state, then an accumulate state), and sums them.
// A classify item then returns the sum; a training item that passes its
// threshold test revisits every leaf: read counts, bump the matching count,
// then a 16-step restoring divider forms P*32768/(P+N) before write-back.
// A new item is taken only after the last one has left the output state;
// a result waiting in the output register does not hold off the next
// input, and only a second finished result waits for the first to be taken.
// The positive and negative counts share one memory word. After reset a
// clearing pass over all NumFerns*2^CodeBits (81920) words runs before the
// first item is taken; configuration writes are taken throughout.
module fern_posterior_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic        i_label,
    input  logic [12:0] i_leaf_code_0,
    input  logic [12:0] i_leaf_code_1,
    input  logic [12:0] i_leaf_code_2,
    input  logic [12:0] i_leaf_code_3,
    input  logic [12:0] i_leaf_code_4,
    input  logic [12:0] i_leaf_code_5,
    input  logic [12:0] i_leaf_code_6,
    input  logic [12:0] i_leaf_code_7,
    input  logic [12:0] i_leaf_code_8,
    input  logic [12:0] i_leaf_code_9,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [18:0] o_posterior_sum,
    output logic        o_updated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [18:0] i_cfg_data
);

    localparam int AB = fpte_pkg::AddrBits;
    localparam int FB = fpte_pkg::FernBits;
    localparam int CB = fpte_pkg::CodeBits;
    localparam int SB = fpte_pkg::SumBits;
    localparam int NB = fpte_pkg::CountBits;

    logic [fpte_pkg::PostBits-1:0] r_post [fpte_pkg::Depth];
    logic [2*NB-1:0]               r_cnt  [fpte_pkg::Depth];

    fpte_pkg::t_state r_state, n_state;
    logic [SB-1:0] r_pos_thr, r_neg_thr;
    logic [CB-1:0] r_code [fpte_pkg::NumFerns];
    logic          r_kind, r_label, r_doit;
    logic [FB-1:0] r_fern, n_fern;
    logic [AB-1:0] r_clr, n_clr;
    logic [SB-1:0] r_sum;
    logic [NB-1:0] r_p, r_n;
    logic [NB:0]   r_den;
    logic [NB+1:0] r_rem;
    logic [15:0]   r_quo;
    logic [4:0]    r_step, n_step;
    logic [fpte_pkg::PostBits-1:0] r_rd_post;
    logic [NB-1:0] r_rd_p, r_rd_n;
    logic          r_out_valid;
    logic          r_out_upd;
    logic [SB-1:0] r_out_sum;

    logic [AB-1:0] w_addr;
    logic          w_clr_we, w_upd_we;
    logic [NB-1:0] w_p_inc, w_n_inc;
    logic [NB+1:0] w_trial;
    logic [fpte_pkg::PostBits-1:0] w_post;
    logic          w_last_fern;
    logic          w_doit;
    logic          w_out_take;

    assign w_last_fern = (r_fern == FB'(fpte_pkg::NumFerns - 1));
    assign w_addr = AB'(r_fern) * AB'(1 << CB) + AB'(r_code[r_fern]);
    assign w_doit = r_kind && (r_label ? (r_sum <= r_pos_thr)
                                       : (r_sum >= r_neg_thr));
    // result register is free, or empties at this edge
    assign w_out_take = (r_state == fpte_pkg::ST_OUT) && (!r_out_valid || i_ready);

    assign o_ready     = (r_state == fpte_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_posterior_sum = r_out_sum;
    assign o_updated   = r_out_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_thr <= fpte_pkg::PosThrReset;
            r_neg_thr <= fpte_pkg::NegThrReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpte_pkg::RegPosThr: r_pos_thr <= i_cfg_data;
                fpte_pkg::RegNegThr: r_neg_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories: one read and one write port each
    assign w_clr_we = (r_state == fpte_pkg::ST_CLEAR);
    assign w_upd_we = (r_state == fpte_pkg::ST_UWRITE);
    assign w_post   = (r_p == '0) ? '0 : r_quo;

    always_ff @(posedge i_clk) begin
        r_rd_post          <= r_post[w_addr];
        {r_rd_p, r_rd_n}   <= r_cnt[w_addr];
        if (w_clr_we) begin
            r_post[r_clr] <= '0;
            r_cnt[r_clr]  <= '0;
        end else if (w_upd_we) begin
            r_post[w_addr] <= w_post;
            r_cnt[w_addr]  <= {r_p, r_n};
        end
    end

    assign w_p_inc = (r_rd_p == fpte_pkg::CountMax) ? r_rd_p : r_rd_p + NB'(1);
    assign w_n_inc = (r_rd_n == fpte_pkg::CountMax) ? r_rd_n : r_rd_n + NB'(1);
    assign w_trial = {r_rem[NB:0], 1'b0} - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        n_fern  = r_fern;
        n_clr   = r_clr;
        n_step  = r_step;
        case (r_state)
            fpte_pkg::ST_CLEAR: begin
                n_clr = r_clr + AB'(1);
                if (r_clr == AB'(fpte_pkg::Depth - 1)) n_state = fpte_pkg::ST_IDLE;
            end
            fpte_pkg::ST_IDLE: begin
                n_fern = '0;
                if (i_valid && o_ready) n_state = fpte_pkg::ST_READ;
            end
            fpte_pkg::ST_READ:  n_state = fpte_pkg::ST_ACC;
            fpte_pkg::ST_ACC: begin
                if (w_last_fern) n_state = fpte_pkg::ST_DECIDE;
                else begin
                    n_fern  = r_fern + FB'(1);
                    n_state = fpte_pkg::ST_READ;
                end
            end
            fpte_pkg::ST_DECIDE: begin
                n_fern  = '0;
                n_state = w_doit ? fpte_pkg::ST_UREAD : fpte_pkg::ST_OUT;
            end
            fpte_pkg::ST_UREAD:  n_state = fpte_pkg::ST_UCOUNT;
            fpte_pkg::ST_UCOUNT: begin
                n_step  = '0;
                n_state = fpte_pkg::ST_UDIV;
            end
            fpte_pkg::ST_UDIV: begin
                n_step = r_step + 5'd1;
                if (r_step == 5'd15) n_state = fpte_pkg::ST_UWRITE;
            end
            fpte_pkg::ST_UWRITE: begin
                if (w_last_fern) n_state = fpte_pkg::ST_OUT;
                else begin
                    n_fern  = r_fern + FB'(1);
                    n_state = fpte_pkg::ST_UREAD;
                end
            end
            fpte_pkg::ST_OUT: begin
                if (w_out_take) n_state = fpte_pkg::ST_IDLE;
            end
            default:             n_state = fpte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpte_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_fern      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fern  <= n_fern;
            r_step  <= n_step;
            if (w_out_take) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fpte_pkg::ST_IDLE: begin
                r_kind  <= i_kind;
                r_label <= i_label;
                r_sum   <= '0;
                r_code[0] <= i_leaf_code_0[CB-1:0];
                r_code[1] <= i_leaf_code_1[CB-1:0];
                r_code[2] <= i_leaf_code_2[CB-1:0];
                r_code[3] <= i_leaf_code_3[CB-1:0];
                r_code[4] <= i_leaf_code_4[CB-1:0];
                r_code[5] <= i_leaf_code_5[CB-1:0];
                r_code[6] <= i_leaf_code_6[CB-1:0];
                r_code[7] <= i_leaf_code_7[CB-1:0];
                r_code[8] <= i_leaf_code_8[CB-1:0];
                r_code[9] <= i_leaf_code_9[CB-1:0];
            end
            fpte_pkg::ST_ACC: r_sum <= r_sum + SB'(r_rd_post);
            fpte_pkg::ST_DECIDE: r_doit <= w_doit;
            fpte_pkg::ST_UCOUNT: begin
                r_p   <= r_label ? w_p_inc : r_rd_p;
                r_n   <= r_label ? r_rd_n : w_n_inc;
                // p < p+n always unless n is 0, so quotient fits in 16 bits
                r_den <= (r_label ? {1'b0, w_p_inc} : {1'b0, r_rd_p})
                       + (r_label ? {1'b0, r_rd_n} : {1'b0, w_n_inc});
                r_rem <= {2'b00, (r_label ? w_p_inc : r_rd_p)};
                r_quo <= '0;
            end
            fpte_pkg::ST_UDIV: begin
                // restoring division of p*2^15 by p+n, one bit a step
                if (r_step == 5'd0) begin
                    if ({1'b0, r_rem[NB:0]} >= {1'b0, r_den}) begin
                        r_rem <= r_rem - {1'b0, r_den};
                        r_quo <= 16'h0001;
                    end
                end else if (!w_trial[NB+1]) begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[NB:0], 1'b0};
                    r_quo <= {r_quo[14:0], 1'b0};
                end
            end
            fpte_pkg::ST_OUT: begin
                if (w_out_take) begin
                    r_out_sum <= r_sum;
                    r_out_upd <= r_doit;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpte_pkg::ST_CLEAR) |-> !o_ready)
        else $error("item taken during clearing pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_out_sum) && r_out_valid)
        else $error("result lost while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpte_pkg::ST_UWRITE) |-> r_doit)
        else $error("write-back without a passing test");

endmodule

/* tb/sv/tb_fern_posterior_table_engine.sv */
// testbench for the fern posterior table engine: scoreboard class with its own
// table predictor, directed and random train/classify traffic; depends on fpte_pkg
`timescale 1ns / 100ps

class fern_scoreboard;
    typedef struct {
        bit [18:0] sum;
        bit        upd;
    } t_verdict;

    bit [15:0]   pos_count [fpte_pkg::Depth];
    bit [15:0]   neg_count [fpte_pkg::Depth];
    bit [15:0]   leaf_post [fpte_pkg::Depth];
    bit [18:0]   pos_thr;
    bit [18:0]   neg_thr;
    t_verdict    verdicts [$];
    int unsigned errors;

    function new();
        pos_thr = fpte_pkg::PosThrReset;
        neg_thr = fpte_pkg::NegThrReset;
        errors  = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [18:0] val);
        if (idx == fpte_pkg::RegPosThr) pos_thr = val;
        else if (idx == fpte_pkg::RegNegThr) neg_thr = val;
    endfunction

    function void note_item(bit kind, bit label, logic [12:0] codes [10]);
        int unsigned addr [fpte_pkg::NumFerns];
        bit [18:0]   sum;
        bit          go;
        longint      p, n;
        sum = 0;
        for (int f = 0; f < fpte_pkg::NumFerns; f++) begin
            addr[f] = f * (1 << fpte_pkg::CodeBits) + codes[f];
            sum += leaf_post[addr[f]];
        end
        go = kind && (label ? (sum <= pos_thr) : (sum >= neg_thr));
        if (go) begin
            for (int f = 0; f < fpte_pkg::NumFerns; f++) begin
                if (label) begin
                    if (pos_count[addr[f]] != fpte_pkg::CountMax) pos_count[addr[f]]++;
                end else begin
                    if (neg_count[addr[f]] != fpte_pkg::CountMax) neg_count[addr[f]]++;
                end
                p = pos_count[addr[f]];
                n = neg_count[addr[f]];
                leaf_post[addr[f]] = (p == 0) ? 16'd0 : 16'((p * 32768) / (p + n));
            end
        end
        verdicts.push_back('{sum, go});
    endfunction

    function void check_result(logic [18:0] sum, logic upd);
        t_verdict v;
        if (verdicts.size() == 0) begin
            $error("result with nothing expected: sum %0d updated %0d", sum, upd);
            errors++;
            return;
        end
        v = verdicts.pop_front();
        if (sum !== v.sum) begin
            $error("posterior_sum: expected %0d, got %0d", v.sum, sum);
            errors++;
        end
        if (upd !== v.upd) begin
            $error("updated: expected %0d, got %0d", v.upd, upd);
            errors++;
        end
    endfunction

    function int pending();
        return verdicts.size();
    endfunction
endclass

module tb_fern_posterior_table_engine;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_kind;
    logic        i_label;
    logic [12:0] codes [10];
    logic        o_valid;
    logic        i_ready;
    logic [18:0] o_posterior_sum;
    logic        o_updated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [18:0] i_cfg_data;

    fern_scoreboard sb;
    bit quiet;
    bit long_hold;

    fern_posterior_table_engine u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_label        (i_label),
        .i_leaf_code_0  (codes[0]),
        .i_leaf_code_1  (codes[1]),
        .i_leaf_code_2  (codes[2]),
        .i_leaf_code_3  (codes[3]),
        .i_leaf_code_4  (codes[4]),
        .i_leaf_code_5  (codes[5]),
        .i_leaf_code_6  (codes[6]),
        .i_leaf_code_7  (codes[7]),
        .i_leaf_code_8  (codes[8]),
        .i_leaf_code_9  (codes[9]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_posterior_sum(o_posterior_sum),
        .o_updated      (o_updated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // input and result transfers seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_item(i_kind, i_label, codes);
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_posterior_sum, o_updated);
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                long_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(bit kind, bit label, logic [12:0] c [10]);
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_label <= label;
        for (int f = 0; f < 10; f++) codes[f] <= c[f];
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // valid is left high; the caller drops it after the last write
    task automatic write_reg(logic [0:0] idx, logic [18:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic fill_codes(output logic [12:0] c [10], input logic [12:0] v);
        for (int f = 0; f < 10; f++) c[f] = v;
    endtask

    task automatic random_item();
        logic [12:0] c [10];
        int          mode;
        mode = $urandom_range(0, 9);
        for (int f = 0; f < 10; f++) begin
            if (mode < 7) c[f] = 13'($urandom_range(0, 3));
            else if (mode < 9) c[f] = 13'($urandom);
            else c[f] = 13'($urandom_range(8188, 8191));
        end
        send_item($urandom_range(0, 3) != 0, 1'($urandom), c);
        if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
    endtask

    initial begin
        logic [12:0] c [10];
        sb          = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = 1'b0;
        i_label     = 1'b0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = fpte_pkg::RegPosThr;
        i_cfg_data  = '0;
        for (int f = 0; f < 10; f++) codes[f] = '0;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset thresholds, code extremes, both labels, no-train cases
        fill_codes(c, 13'd0);    send_item(1'b0, 1'b1, c);
        fill_codes(c, 13'h1FFF); send_item(1'b0, 1'b0, c);
        fill_codes(c, 13'd0);    send_item(1'b1, 1'b1, c);
        send_item(1'b1, 1'b1, c);   // full sum, above positive threshold
        send_item(1'b0, 1'b0, c);
        send_item(1'b1, 1'b0, c);   // negative trains on a full sum
        send_item(1'b1, 1'b0, c);
        fill_codes(c, 13'h1FFF); send_item(1'b1, 1'b0, c);   // zero sum, no negative train
        send_item(1'b1, 1'b1, c);
        for (int f = 0; f < 10; f++) c[f] = (f % 2) ? 13'h1555 : 13'h0AAA;
        send_item(1'b1, 1'b1, c);
        send_item(1'b0, 1'b1, c);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(fpte_pkg::RegPosThr, 19'h7FFFF);
                         write_reg(fpte_pkg::RegNegThr, 19'd0); end
                1: begin write_reg(fpte_pkg::RegPosThr, 19'd0);
                         write_reg(fpte_pkg::RegNegThr, 19'h7FFFF); end
                2: begin write_reg(fpte_pkg::RegPosThr, 19'($urandom_range(0, 327680)));
                         write_reg(fpte_pkg::RegNegThr, 19'($urandom_range(0, 327680))); end
                3: begin write_reg(fpte_pkg::RegPosThr, 19'd327680);
                         write_reg(fpte_pkg::RegNegThr, 19'd32768); end
                default: begin write_reg(fpte_pkg::RegPosThr, fpte_pkg::PosThrReset);
                         write_reg(fpte_pkg::RegNegThr, fpte_pkg::NegThrReset);
                         quiet = 1'b1; end
            endcase
            i_cfg_valid <= 1'b0;
            for (int k = 0; k < 160; k++) begin
                if (ph == 2 && k == 40) long_hold = 1'b1;
                random_item();
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
hdl/fpte_pkg.sv
hdl/fern_posterior_table_engine.sv
tb/sv/tb_fern_posterior_table_engine.sv
